/* design/c2p_pkg.sv */
// ----------------------------------------------------------------------------
// c2p_pkg: shared types and constants for the Cartesian to polar converter
// Widths, payload structs, pipeline cell record and the CORDIC arctan table.
// ----------------------------------------------------------------------------
`default_nettype none

package c2p_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int DEF_STAGES = 16;
  localparam int GUARD_BITS = 24;
  // sign extension bits above the negated input in the CORDIC datapath
  localparam int EXT_W      = 2;
  localparam int CORDIC_W   = EXT_W + DATA_WIDTH + 1 + GUARD_BITS;
  localparam int Z_W        = 32;
  localparam int RAD_W      = 2 * DATA_WIDTH;
  localparam int REM_W      = DATA_WIDTH + 1;
  localparam int SQ_STEPS   = DATA_WIDTH;
  localparam int MAG_MAX    = 46341;

  localparam logic [Z_W-1:0] Z_PI = {1'b1, {(Z_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_in;
    logic signed [DATA_WIDTH-1:0] y_in;
    logic                         last_in;
  } c2p_in_t;

  typedef struct packed {
    logic        [DATA_WIDTH-1:0] magnitude_out;
    logic signed [DATA_WIDTH-1:0] angle_out;
    logic                         last_out;
  } c2p_out_t;

  // Record handed from cell to cell.
  typedef struct packed {
    logic signed [CORDIC_W-1:0] gx;
    logic signed [CORDIC_W-1:0] gy;
    logic [Z_W-1:0]             z;
    logic [RAD_W-1:0]           rad;   // radicand bits not yet brought down
    logic [REM_W-1:0]           rem;   // partial remainder
    logic [DATA_WIDTH-1:0]      root;  // partial root
    logic                       last;
  } c2p_cell_t;

  // atan(2^-i) in turns, scaled by 2^32
  function automatic logic [Z_W-1:0] atan_turn(input logic [4:0] idx);
    logic [Z_W-1:0] t;
    case (idx)
      5'd0:    t = 32'h20000000;
      5'd1:    t = 32'h12E4051E;
      5'd2:    t = 32'h09FB385B;
      5'd3:    t = 32'h051111D4;
      5'd4:    t = 32'h028B0D43;
      5'd5:    t = 32'h0145D7E1;
      5'd6:    t = 32'h00A2F61E;
      5'd7:    t = 32'h00517C55;
      5'd8:    t = 32'h0028BE53;
      5'd9:    t = 32'h00145F2F;
      5'd10:   t = 32'h000A2F98;
      5'd11:   t = 32'h000517CC;
      5'd12:   t = 32'h00028BE6;
      5'd13:   t = 32'h000145F3;
      5'd14:   t = 32'h0000A2FA;
      5'd15:   t = 32'h0000517D;
      5'd16:   t = 32'h000028BE;
      5'd17:   t = 32'h0000145F;
      5'd18:   t = 32'h00000A30;
      5'd19:   t = 32'h00000518;
      5'd20:   t = 32'h0000028C;
      5'd21:   t = 32'h00000146;
      5'd22:   t = 32'h000000A3;
      5'd23:   t = 32'h00000051;
      5'd24:   t = 32'h00000029;
      5'd25:   t = 32'h00000014;
      5'd26:   t = 32'h0000000A;
      5'd27:   t = 32'h00000005;
      5'd28:   t = 32'h00000003;
      5'd29:   t = 32'h00000001;
      5'd30:   t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

/* design/c2p_prep.sv */
// ----------------------------------------------------------------------------
// c2p_prep: input conditioning
// Folds the pair into the right half plane, scales it for CORDIC and forms
// x*x + y*y over two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_prep import c2p_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      valid_i,
  input  wire c2p_in_t   data_i,
  output logic           valid_o,
  output c2p_cell_t      data_o
);

  logic signed [DATA_WIDTH:0] xe, ye, sx, sy, axe, aye;
  logic [DATA_WIDTH-1:0]      ax, ay;
  logic [RAD_W-1:0]           sqx_nxt, sqy_nxt;

  logic                       s1_valid_r;
  logic signed [DATA_WIDTH:0] s1_sx_r, s1_sy_r;
  logic [Z_W-1:0]             s1_z_r;
  logic [RAD_W-1:0]           s1_sqx_r, s1_sqy_r;
  logic                       s1_last_r;

  logic                       s2_valid_r;
  c2p_cell_t                  s2_data_r, s2_data_nxt;

  assign xe  = {data_i.x_in[DATA_WIDTH-1], data_i.x_in};
  assign ye  = {data_i.y_in[DATA_WIDTH-1], data_i.y_in};
  assign sx  = xe[DATA_WIDTH] ? -xe : xe;
  assign sy  = xe[DATA_WIDTH] ? -ye : ye;
  assign axe = xe[DATA_WIDTH] ? -xe : xe;
  assign aye = ye[DATA_WIDTH] ? -ye : ye;
  // |v| <= 2^(DATA_WIDTH-1) fits unsigned
  assign ax  = axe[DATA_WIDTH-1:0];
  assign ay  = aye[DATA_WIDTH-1:0];
  assign sqx_nxt = RAD_W'(ax) * RAD_W'(ax);
  assign sqy_nxt = RAD_W'(ay) * RAD_W'(ay);

  always_comb begin
    s2_data_nxt.gx   = {{EXT_W{s1_sx_r[DATA_WIDTH]}}, s1_sx_r, {GUARD_BITS{1'b0}}};
    s2_data_nxt.gy   = {{EXT_W{s1_sy_r[DATA_WIDTH]}}, s1_sy_r, {GUARD_BITS{1'b0}}};
    s2_data_nxt.z    = s1_z_r;
    s2_data_nxt.rad  = s1_sqx_r + s1_sqy_r;
    s2_data_nxt.rem  = '0;
    s2_data_nxt.root = '0;
    s2_data_nxt.last = s1_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= valid_i;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sx_r   <= sx;
      s1_sy_r   <= sy;
      s1_z_r    <= xe[DATA_WIDTH] ? Z_PI : '0;
      s1_sqx_r  <= sqx_nxt;
      s1_sqy_r  <= sqy_nxt;
      s1_last_r <= data_i.last_in;
      s2_data_r <= s2_data_nxt;
    end
  end

  assign valid_o = s2_valid_r;
  assign data_o  = s2_data_r;

endmodule

`default_nettype wire

/* design/c2p_cell.sv */
// ----------------------------------------------------------------------------
// c2p_cell: one cell of the converter row
// One CORDIC vectoring micro-rotation if DO_CORDIC and one root digit if DO_SQRT.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_cell import c2p_pkg::*; #(
  parameter int IDX       = 0,
  parameter bit DO_CORDIC = 1'b1,
  parameter bit DO_SQRT   = 1'b1
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      valid_i,
  input  wire c2p_cell_t data_i,
  output logic           valid_o,
  output c2p_cell_t      data_o
);

  logic signed [CORDIC_W-1:0] dx, dy;
  logic [Z_W-1:0]             tab;
  logic [REM_W+1:0]           rem_sh, trial;
  logic                       fits;

  logic                       valid_r;
  c2p_cell_t                  data_r, data_nxt;

  assign dx  = data_i.gy >>> IDX;
  assign dy  = data_i.gx >>> IDX;
  assign tab = atan_turn(5'(IDX));

  // bring down the next two radicand bits
  assign rem_sh = {data_i.rem, data_i.rad[RAD_W-1 -: 2]};
  assign trial  = {1'b0, data_i.root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_comb begin
    data_nxt = data_i;
    if (DO_CORDIC) begin
      if (!data_i.gy[CORDIC_W-1]) begin
        data_nxt.gx = data_i.gx + dx;
        data_nxt.gy = data_i.gy - dy;
        data_nxt.z  = data_i.z + tab;
      end else begin
        data_nxt.gx = data_i.gx - dx;
        data_nxt.gy = data_i.gy + dy;
        data_nxt.z  = data_i.z - tab;
      end
    end
    if (DO_SQRT) begin
      data_nxt.rad  = {data_i.rad[RAD_W-3:0], 2'b00};
      data_nxt.rem  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      data_nxt.root = {data_i.root[DATA_WIDTH-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

`default_nettype wire

/* design/c2p_out.sv */
// ----------------------------------------------------------------------------
// c2p_out: final rounding and output skid buffer
// Rounds root and angle, then holds results in an output register plus a
// skid register so the row can be frozen by a registered enable.
// ----------------------------------------------------------------------------
`default_nettype none

module c2p_out import c2p_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      valid_i,
  input  wire c2p_cell_t data_i,
  output logic           en,
  output logic           out_valid,
  input  wire logic      out_stall,
  output c2p_out_t       out_data
);

  localparam int DROP = Z_W - DATA_WIDTH;

  logic [Z_W-1:0]   z_rnd;
  logic             origin;
  c2p_out_t         res;
  logic             take;

  logic             out_valid_r, out_valid_nxt;
  c2p_out_t         out_data_r, out_data_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  c2p_out_t         skid_data_r, skid_data_nxt;

  assign z_rnd  = data_i.z + Z_W'({1'b1, {(DROP-1){1'b0}}});
  assign origin = (data_i.root == '0) && (data_i.rem == '0);

  always_comb begin
    res.magnitude_out = (data_i.rem > REM_W'(data_i.root)) ? data_i.root + 1'b1
                                                           : data_i.root;
    res.angle_out     = origin ? '0 : z_rnd[Z_W-1 -: DATA_WIDTH];
    res.last_out      = data_i.last;
  end

  assign en   = !skid_valid_r;
  assign take = valid_i && !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt  = take;
        out_data_nxt   = res;
      end
    end else if (take) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a transaction while output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled without a stalled output");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.magnitude_out <= DATA_WIDTH'(MAG_MAX)))
    else $error("magnitude out of range");

  a_origin_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.magnitude_out == '0)) |-> (out_data_r.angle_out == '0))
    else $error("origin gave a nonzero angle");
`endif

endmodule

`default_nettype wire

/* design/cartesian_to_polar.sv */
// ----------------------------------------------------------------------------
// cartesian_to_polar: streaming Cartesian to polar converter
// Path: an accepted input passes the prep registers, the row of cells and the
//   output register before it shows on out_valid.
// Throughput: one transaction per cycle while the skid register is empty, set
//   by the row of cells that each take a new record every enabled cycle.
// Reset: synchronous active-low rst_n clears all valid bits; no data pending.
// ----------------------------------------------------------------------------
`default_nettype none

// Structure:
//   c2p_prep  - stage 1 folds x < 0 into the right half plane (angle seed pi)
//               and squares |x|, |y|; stage 2 adds the squares and scales
//               the folded pair by 2^GUARD_BITS.
//   c2p_cell  - a row of cells alike but for parameters. Cell i does CORDIC
//               micro-rotation i (while i < STAGES) and brings down one root
//               digit (while i < 16), handing its record to the next cell.
//   c2p_out   - rounds root to nearest using the final remainder, rounds the
//               32-bit turn accumulator to 16 bits, forces the origin to
//               angle 0, and buffers in an output register plus skid.
//
// Flow control: the whole row advances on a single enable that is the
// registered "skid empty" flag, so in_stall has no combinational path from
// out_stall. A stalled output costs one extra transaction into the skid,
// after which the row and the input freeze until the output drains.
module cartesian_to_polar import c2p_pkg::*; #(
  parameter int STAGES = DEF_STAGES
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire c2p_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output c2p_out_t      out_data
);

  // number of cells: enough for both the CORDIC steps and the root digits
  localparam int NCELL = (STAGES > SQ_STEPS) ? STAGES : SQ_STEPS;

  logic      en;
  logic      chain_v [0:NCELL];
  c2p_cell_t chain_d [0:NCELL];

  // the row only moves when the skid register is empty
  assign in_stall = !en;

  c2p_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid),
    .data_i  (in_data),
    .valid_o (chain_v[0]),
    .data_o  (chain_d[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    c2p_cell #(
      .IDX       (i),
      .DO_CORDIC (i < STAGES),
      .DO_SQRT   (i < SQ_STEPS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (chain_v[i]),
      .data_i  (chain_d[i]),
      .valid_o (chain_v[i+1]),
      .data_o  (chain_d[i+1])
    );
  end

  c2p_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (chain_v[NCELL]),
    .data_i    (chain_d[NCELL]),
    .en        (en),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* bench/cartesian_to_polar_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_polar_tb: self-checking bench for the Cartesian to polar block
// Streams corner pairs and then random pairs through the converter, with both
// sides idling at random in phases 1 and 2. Every result is checked against
// a bit-exact model of the rounded magnitude and the CORDIC angle, in order.
// ----------------------------------------------------------------------------
module cartesian_to_polar_tb;
  import c2p_pkg::*;

  // atan(2^-i) in turns, 2^32 to a full turn; only the stages in use
  localparam logic [31:0] ATAN_TURN_TBL [DEF_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // values on the edges of the signed 16-bit range and around zero
  localparam logic signed [DATA_WIDTH-1:0] CORNER_VALS [6] = '{
    -16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
  };

  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int HOLD_CYCLES = 80;
  // idle time at the end to flush anything stray
  localparam int SETTLE_CYCLES = 40;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts each polar result and checks arrivals in order
  // --------------------------------------------------------------------------
  class polar_scoreboard;
    c2p_out_t awaited[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    // exact rounded length plus a bit-true CORDIC vectoring angle
    function c2p_out_t polar_of(c2p_in_t p);
      c2p_out_t        r;
      longint          x, y, gx, gy, dx, dy;
      longint unsigned sq, root, cand;
      logic [31:0]     z;
      logic [32:0]     zr;
      x = $signed(p.x_in);
      y = $signed(p.y_in);
      sq = x * x + y * y;
      root = 0;
      for (int b = DATA_WIDTH; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= sq) root = cand;
      end
      if (sq - root * root > root) root = root + 1;
      r.magnitude_out = root[DATA_WIDTH-1:0];
      r.angle_out = '0;
      if (x != 0 || y != 0) begin
        z = '0;
        // left half plane: rotate by pi first
        if (x < 0) begin
          x = -x;
          y = -y;
          z = 32'h8000_0000;
        end
        gx = x <<< GUARD_BITS;
        gy = y <<< GUARD_BITS;
        for (int i = 0; i < DEF_STAGES; i++) begin
          dx = gy >>> i;
          dy = gx >>> i;
          if (gy >= 0) begin
            gx = gx + dx;
            gy = gy - dy;
            z  = z + ATAN_TURN_TBL[i];
          end else begin
            gx = gx - dx;
            gy = gy + dy;
            z  = z - ATAN_TURN_TBL[i];
          end
        end
        // round half up to the top 16 bits; +pi wraps to -pi
        zr = {1'b0, z} + 33'h0_0000_8000;
        r.angle_out = zr[31:16];
      end
      r.last_out = p.last_in;
      return r;
    endfunction

    function void note_pair(c2p_in_t p);
      awaited.push_back(polar_of(p));
    endfunction

    function void check_result(c2p_out_t got);
      c2p_out_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected result mag %0d ang %0d last %0b", $time,
                   got.magnitude_out, got.angle_out, got.last_out);
        return;
      end
      want = awaited.pop_front();
      if (got.magnitude_out !== want.magnitude_out || got.angle_out !== want.angle_out ||
          got.last_out !== want.last_out) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: mismatch expected mag %0d ang %0d last %0b, got mag %0d ang %0d last %0b",
                   $time, want.magnitude_out, want.angle_out, want.last_out,
                   got.magnitude_out, got.angle_out, got.last_out);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block under test
  // --------------------------------------------------------------------------
  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  c2p_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  c2p_out_t out_data;

  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  logic     drain_hold = 1'b0;   // long receiver hold-off in progress

  polar_scoreboard sb = new();

  always #5 clk = ~clk;

  cartesian_to_polar DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // --------------------------------------------------------------------------
  // Monitors: sample both channels on the rising edge. Inputs only move on the
  // falling edge, so each transaction is seen once with settled values.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_pair(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver: random back-pressure, or solid stall during a hold-off.
  always @(negedge clk) begin
    out_stall <= drain_hold || ($urandom_range(99) < recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Driver tasks. Each starts and ends just after a falling edge.
  // --------------------------------------------------------------------------

  // Offer one pair, after a random run of idle cycles, and keep it steady
  // until the block takes it.
  task automatic send_pair(input c2p_in_t p);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end
  endtask

  task automatic send_xy(input int x, input int y, input bit last);
    c2p_in_t p;
    p.x_in    = x[DATA_WIDTH-1:0];
    p.y_in    = y[DATA_WIDTH-1:0];
    p.last_in = last;
    send_pair(p);
  endtask

  // Random pair with a mix of shapes: mostly full range, some near the
  // origin, on an axis, on the range edges, or on a diagonal.
  function automatic c2p_in_t random_pair();
    c2p_in_t p;
    int      shape;
    shape = $urandom_range(9);
    p.x_in = DATA_WIDTH'($urandom());
    p.y_in = DATA_WIDTH'($urandom());
    case (shape)
      6: begin
        p.x_in = DATA_WIDTH'(int'($urandom_range(128)) - 64);
        p.y_in = DATA_WIDTH'(int'($urandom_range(128)) - 64);
      end
      7: begin
        if ($urandom_range(1)) p.x_in = '0;
        else p.y_in = '0;
      end
      8: begin
        p.x_in = CORNER_VALS[$urandom_range(5)];
        p.y_in = CORNER_VALS[$urandom_range(5)];
      end
      9: begin
        p.y_in = $urandom_range(1) ? p.x_in : -p.x_in;
      end
      default: ;
    endcase
    p.last_in = ($urandom_range(7) == 0);
    return p;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_pair(random_pair());
  endtask

  // Stop offering and wait for every predicted result to come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.awaited.size() != 0) @(negedge clk);
  endtask

  task automatic hold_output(input int cycles);
    @(negedge clk);
    drain_hold <= 1'b1;
    repeat (cycles) @(negedge clk);
    drain_hold <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 1: light sender idling, heavy receiver back-pressure
    send_idle_pct = 12;
    recv_idle_pct = 58;

    // origin gives zero length and zero angle
    send_xy(0, 0, 1'b0);
    // positive and negative axes; the negative real axis lands on -pi
    send_xy(32767, 0, 1'b1);
    send_xy(-32768, 0, 1'b0);
    send_xy(-1, 0, 1'b1);
    send_xy(-5, 0, 1'b0);
    send_xy(1, 0, 1'b0);
    send_xy(0, 32767, 1'b0);
    send_xy(0, -32768, 1'b1);
    send_xy(0, 1, 1'b0);
    send_xy(0, -1, 1'b0);
    // largest length the block can produce
    send_xy(-32768, -32768, 1'b1);
    send_xy(32767, 32767, 1'b0);
    send_xy(-32768, 32767, 1'b0);
    send_xy(32767, -32768, 1'b1);
    // just off the negative real axis, either side of the wrap
    send_xy(-32768, 1, 1'b0);
    send_xy(-32768, -1, 1'b0);
    send_xy(-1, 1, 1'b1);
    send_xy(-1, -1, 1'b0);
    send_xy(1, 1, 1'b0);
    send_xy(3, 4, 1'b1);
    send_xy(100, -100, 1'b0);
    send_xy(-12345, 23456, 1'b1);

    send_random(RANDOM_PER_PHASE);
    // sender pauses until the block is empty
    wait_for_drain();

    // phase 2: the other way round
    send_idle_pct = 58;
    recv_idle_pct = 12;
    send_random(RANDOM_PER_PHASE);
    wait_for_drain();

    // phase 3: no idling; a long receiver hold-off at the start fills the
    // pipeline and skid so the input stalls while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      hold_output(HOLD_CYCLES);
    join_none
    send_random(RANDOM_PER_PHASE);
    wait_for_drain();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
